FILE: src/cemi_pkg.sv
// cemi_pkg: shared types, codes and constants of the cEMI frame parser
package cemi_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_TRUNC = 2'd2
  } status_t;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned FLAGS_W = 11;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [10:0]      MIN_FRAME_BYTES = 11'd10;

  localparam logic [9:0] APCI_MASK_HI   = 10'h3C0;
  localparam logic [9:0] APCI_MASK_DESC = 10'h3FC;
  localparam logic [9:0] APCI_PROPRESP  = 10'h3D6;
  localparam logic [9:0] APCI_GVWRITE   = 10'h080;
  localparam logic [9:0] APCI_GVRESP    = 10'h040;
  localparam logic [9:0] APCI_DEVDESC   = 10'h340;
  localparam logic [9:0] APCI_MEMRESP   = 10'h240;
  localparam logic [9:0] APCI_IARESP    = 10'h140;
  localparam logic [7:0] TPCI_MASK_CTL  = 8'hC3;
  localparam logic [7:0] TPCI_ACK       = 8'hC2;
  localparam logic [7:0] TPCI_NAK       = 8'hC3;
  localparam logic [7:0] TPCI_CONNECT   = 8'h80;
  localparam logic [7:0] TPCI_DISCONN   = 8'h81;
  localparam logic [7:0] TPCI_MASK_NUM  = 8'hC0;
  localparam logic [7:0] TPCI_DATA_CON  = 8'h40;
  localparam logic [2:0] HOP_MASK       = 3'h7;

  localparam int unsigned FLAG_GVWRITE  = 0;
  localparam int unsigned FLAG_GVRESP   = 1;
  localparam int unsigned FLAG_DEVDESC  = 2;
  localparam int unsigned FLAG_MEMRESP  = 3;
  localparam int unsigned FLAG_PROPRESP = 4;
  localparam int unsigned FLAG_IARESP   = 5;
  localparam int unsigned FLAG_CONNECT  = 6;
  localparam int unsigned FLAG_DISCONN  = 7;
  localparam int unsigned FLAG_ACK      = 8;
  localparam int unsigned FLAG_NAK      = 9;
  localparam int unsigned FLAG_DATA_CON = 10;

  typedef struct packed {
    logic [POS_W-1:0] byte_position;
    logic [7:0]       info_length;
    logic [7:0]       code_reg;
    logic [7:0]       control_two;
    logic [15:0]      source_reg;
    logic [15:0]      dest_reg;
    logic [7:0]       length_reg;
    logic [31:0]      apdu_head;
  } parse_state_t;

  typedef struct packed {
    status_t            frame_status;
    logic [7:0]         message_code;
    logic               is_group;
    logic [2:0]         hop_count;
    logic [15:0]        source_addr;
    logic [15:0]        dest_addr;
    logic [7:0]         apdu_length;
    logic [FLAGS_W-1:0] type_flags;
    logic [3:0]         seq_number;
    logic [9:0]         apci_code;
    logic [15:0]        apdu_word;
  } result_t;

endpackage

FILE: src/cemi_in_if.sv
// cemi_in_if: byte channel carrying raw cEMI frame bytes
interface cemi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

FILE: src/cemi_out_if.sv
// cemi_out_if: result channel carrying one decoded frame header
interface cemi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  message_code;
  logic        is_group;
  logic [2:0]  hop_count;
  logic [15:0] source_addr;
  logic [15:0] dest_addr;
  logic [7:0]  apdu_length;
  logic [10:0] type_flags;
  logic [3:0]  seq_number;
  logic [9:0]  apci_code;
  logic [15:0] apdu_word;

  modport source (
    output valid, frame_status, message_code, is_group, hop_count, source_addr,
           dest_addr, apdu_length, type_flags, seq_number, apci_code, apdu_word,
    input  ready
  );
  modport sink (
    input  valid, frame_status, message_code, is_group, hop_count, source_addr,
           dest_addr, apdu_length, type_flags, seq_number, apci_code, apdu_word,
    output ready
  );
endinterface

FILE: src/cemi_decode.sv
// cemi_decode: length checks and frame-type decode on the captured header
module cemi_decode (
  input  cemi_pkg::parse_state_t st,
  output cemi_pkg::result_t      res
);
  import cemi_pkg::*;

  logic [10:0] n;
  logic [10:0] hdr;
  logic [10:0] hdr_end;
  logic [10:0] apdu_end;
  logic [7:0]  len;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic        grp;
  logic [9:0]  apci;
  logic [FLAGS_W-1:0] flags;

  always_comb begin
    n        = {1'b0, st.byte_position} + 11'd1;
    hdr      = {3'b000, st.info_length} + 11'd2;
    hdr_end  = hdr + 11'd8;
    apdu_end = hdr + 11'd7 + {3'b000, st.length_reg};
    len      = st.length_reg;
    b0       = st.apdu_head[7:0];
    b1       = st.apdu_head[15:8];
    grp      = st.control_two[7];
    apci     = (len >= 8'd2) ? {b0[1:0], b1} : 10'd0;

    flags = '0;
    flags[FLAG_GVWRITE] = (apci & APCI_MASK_HI) == APCI_GVWRITE;
    flags[FLAG_GVRESP]  = (apci & APCI_MASK_HI) == APCI_GVRESP;
    flags[FLAG_DEVDESC] = (len >= 8'd2) && ((apci & APCI_MASK_DESC) == APCI_DEVDESC);
    flags[FLAG_MEMRESP] = (len >= 8'd4) && !grp && ((apci & APCI_MASK_HI) == APCI_MEMRESP);
    flags[FLAG_PROPRESP] = (len >= 8'd6) && !grp && (apci == APCI_PROPRESP);
    flags[FLAG_IARESP]  = (len >= 8'd2) && grp && (apci == APCI_IARESP);
    if (len >= 8'd1) begin
      flags[FLAG_CONNECT]  = b0 == TPCI_CONNECT;
      flags[FLAG_DISCONN]  = b0 == TPCI_DISCONN;
      flags[FLAG_ACK]      = (b0 & TPCI_MASK_CTL) == TPCI_ACK;
      flags[FLAG_NAK]      = (b0 & TPCI_MASK_CTL) == TPCI_NAK;
      flags[FLAG_DATA_CON] = (b0 & TPCI_MASK_NUM) == TPCI_DATA_CON;
    end

    res = '0;
    priority if (n < MIN_FRAME_BYTES) begin
      res.frame_status = STATUS_SHORT;
    end else if (n < hdr_end) begin
      res.frame_status = STATUS_SHORT;
      res.message_code = st.code_reg;
    end else begin
      res.message_code = st.code_reg;
      res.is_group     = grp;
      res.hop_count    = st.control_two[6:4] & HOP_MASK;
      res.source_addr  = st.source_reg;
      res.dest_addr    = st.dest_reg;
      res.apdu_length  = st.length_reg;
      if (n < apdu_end) begin
        res.frame_status = STATUS_TRUNC;
      end else begin
        res.frame_status = STATUS_OK;
        res.type_flags   = flags;
        res.seq_number   = (len >= 8'd1) ? b0[5:2] : 4'd0;
        res.apci_code    = apci;
        res.apdu_word    = {st.apdu_head[23:16], st.apdu_head[31:24]};
      end
    end
  end

endmodule

FILE: src/cemi_frame_parser_core.sv
// cemi_frame_parser_core: byte-serial cEMI frame header parser, top level
//
//  channel | dir | beat                               | when
//  frame   | in  | data_byte, last_byte               | one per frame byte
//  result  | out | status, header fields, apci, flags | one per frame, on last byte
//
// one byte is taken per cycle when not stalled; the header capture and the
// decode of the last byte sit between the parse registers and the result register
// a result appears the cycle after its last byte is accepted
// frame stalls only while a result waits in the result register
// rst clears the byte count, header registers and result valid
module cemi_frame_parser_core (
  input logic            clk,
  input logic            rst,
  cemi_in_if.sink        frame,
  cemi_out_if.source     result
);
  import cemi_pkg::*;

  parse_state_t st;
  parse_state_t cap;
  parse_state_t st_next;
  result_t      res_next;
  result_t      res;
  logic         res_valid;
  logic         accept;
  logic [8:0]   hdr;
  logic [POS_W-1:0] offset;
  logic [POS_W-1:0] k;

  assign frame.ready = !res_valid || result.ready;
  assign accept      = frame.valid && frame.ready;

  // header capture at the current byte position
  always_comb begin
    cap    = st;
    hdr    = {1'b0, st.info_length} + 9'd2;
    offset = st.byte_position - {1'b0, hdr};
    k      = offset - POS_W'(7);
    priority if (st.byte_position == '0) begin
      cap.code_reg = frame.data_byte;
    end else if (st.byte_position == POS_W'(1)) begin
      cap.info_length = frame.data_byte;
    end else if (st.byte_position >= {1'b0, hdr}) begin
      priority case (offset)
        POS_W'(1): cap.control_two = frame.data_byte;
        POS_W'(2): cap.source_reg[15:8] = frame.data_byte;
        POS_W'(3): cap.source_reg[7:0] = frame.data_byte;
        POS_W'(4): cap.dest_reg[15:8] = frame.data_byte;
        POS_W'(5): cap.dest_reg[7:0] = frame.data_byte;
        POS_W'(6): cap.length_reg = frame.data_byte;
        default: begin
          if (offset >= POS_W'(7) && k < POS_W'(4) &&
              st.length_reg > {6'b000000, k[1:0]}) begin
            cap.apdu_head[8*k[1:0] +: 8] = st.apdu_head[8*k[1:0] +: 8] | frame.data_byte;
          end
        end
      endcase
    end else begin
      cap = st;
    end
  end

  // saturating byte count
  always_comb begin
    st_next = cap;
    if (st.byte_position != POS_MAX) begin
      st_next.byte_position = st.byte_position + POS_W'(1);
    end
  end

  cemi_decode u_decode (
    .st  (cap),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      if (frame.last_byte) begin
        st <= '0;
      end else begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && frame.last_byte) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame.last_byte) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.frame_status = res.frame_status;
  assign result.message_code = res.message_code;
  assign result.is_group     = res.is_group;
  assign result.hop_count    = res.hop_count;
  assign result.source_addr  = res.source_addr;
  assign result.dest_addr    = res.dest_addr;
  assign result.apdu_length  = res.apdu_length;
  assign result.type_flags   = res.type_flags;
  assign result.seq_number   = res.seq_number;
  assign result.apci_code    = res.apci_code;
  assign result.apdu_word    = res.apdu_word;

endmodule

FILE: src/cemi_frame_parser_checker.sv
// cemi_frame_parser_checker: port-level assertions bound to the parser top level
module cemi_frame_parser_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  frame_status,
  input logic [7:0]  message_code,
  input logic [10:0] type_flags,
  input logic [3:0]  seq_number,
  input logic [9:0]  apci_code,
  input logic [15:0] apdu_word,
  input logic [15:0] source_addr,
  input logic [15:0] dest_addr
);
  import cemi_pkg::*;

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) &&
    $stable(message_code) && $stable(apci_code))
    else $error("stalled result changed");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result without a last byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result register");

  a_trunc_empty_apdu: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status == STATUS_TRUNC || frame_status == STATUS_SHORT) |->
    type_flags == '0 && seq_number == '0 && apci_code == '0 && apdu_word == '0)
    else $error("apdu fields set on short or truncated frame");

  a_short_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == STATUS_SHORT |-> source_addr == '0 && dest_addr == '0)
    else $error("addresses set on short frame");

endmodule

bind cemi_frame_parser_core cemi_frame_parser_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (frame.valid),
  .in_ready     (frame.ready),
  .in_last      (frame.last_byte),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .frame_status (result.frame_status),
  .message_code (result.message_code),
  .type_flags   (result.type_flags),
  .seq_number   (result.seq_number),
  .apci_code    (result.apci_code),
  .apdu_word    (result.apdu_word),
  .source_addr  (result.source_addr),
  .dest_addr    (result.dest_addr)
);
